// ----- design/pcr_pkg.sv -----
package pcr_pkg;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 31;
    localparam int DIFF_W    = 33;
    localparam int SQ_W      = 66;
    localparam int PROD_W    = 64;
    localparam int DEF_MAX_CHORDS = 63;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;

    typedef struct packed {
        logic                      fin;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    typedef struct packed {
        logic    valid;
        vertex_t data;
    } vq_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_CHECK,
        ST_MRX,
        ST_MRY,
        ST_DIV,
        ST_MOVE,
        ST_CLOSE,
        ST_RD,
        ST_OUT
    } state_t;

endpackage

// ----- design/polyline_chord_resampler_core.sv -----
// Equal-chord polyline resampler. Vertices (signed Q16.16, tlast marks the
// last vertex of a curve) enter a two-word queue; the engine behind it walks
// the anchor toward each vertex one chord at a time and collects the points
// of that vertex in a local buffer, then streams them out once the vertex is
// finished, so overrun and item_done are known for every word. Cost: a first
// vertex goes straight into the buffer; a later vertex takes two multiplies
// and the 33-step square root to find that no chord fits, plus, per chord,
// the square root and then two 64-step dividers in parallel, plus a buffer
// read per output word. The square root and the dividers set this.
module polyline_chord_resampler_core #(
    parameter int MAX_CHORDS = pcr_pkg::DEF_MAX_CHORDS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vertex_x, vertex_y
    input  logic        s_tlast,   // final_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // out_x, out_y
    output logic        m_tlast,   // curve_end
    output logic [1:0]  m_tuser    // item_done, overrun
);

    localparam int DEPTH = MAX_CHORDS + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_CHORDS + 1);
    localparam int XW    = pcr_pkg::COORD_W;

    logic [pcr_pkg::RADIUS_W-1:0] radius_reg;
    logic [pcr_pkg::RADIUS_W-1:0] r_eff;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pcr_pkg::ADDR_RADIUS[2]) ? {1'b0, radius_reg} : 32'd0;
    assign r_eff  = (radius_reg == '0) ? pcr_pkg::RADIUS_W'(1) : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= pcr_pkg::RADIUS_RESET;
        else if (psel && penable && pwrite && (paddr[2] == pcr_pkg::ADDR_RADIUS[2]))
            radius_reg <= pwdata[pcr_pkg::RADIUS_W-1:0];
    end

    // front: vertex queue
    pcr_pkg::vertex_t in_v;
    pcr_pkg::vq_out_t vq;
    logic             pop;

    assign in_v.x   = s_tdata[31:0];
    assign in_v.y   = s_tdata[63:32];
    assign in_v.fin = s_tlast;

    pcr_vertex_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (in_v),
        .q        (vq),
        .pop      (pop)
    );

    // back: chord engine
    pcr_pkg::state_t state_reg, state_next;

    logic signed [XW-1:0] vx_reg, vy_reg, ax_reg, ay_reg;
    logic                 fin_reg, started_reg, over_reg, end_reg;
    logic [NW-1:0]        n_reg;
    logic [CW-1:0]        chords_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [pcr_pkg::DIFF_W-1:0] ux_reg, uy_reg, dist_reg;
    logic                 negx_reg, negy_reg;
    logic [pcr_pkg::SQ_W-1:0]   sx_reg;
    logic [pcr_pkg::PROD_W-1:0] px_reg;

    logic signed [pcr_pkg::DIFF_W-1:0] dx, dy;
    logic [pcr_pkg::DIFF_W-1:0]        mul_a, mul_b;
    logic [pcr_pkg::SQ_W-1:0]          prod;

    assign dx    = {vx_reg[XW-1], vx_reg} - {ax_reg[XW-1], ax_reg};
    assign dy    = {vy_reg[XW-1], vy_reg} - {ay_reg[XW-1], ay_reg};
    assign mul_a = (state_reg == pcr_pkg::ST_SQY || state_reg == pcr_pkg::ST_MRY) ? uy_reg :
                   (state_reg == pcr_pkg::ST_SQX) ? (dx[pcr_pkg::DIFF_W-1] ? -dx : dx) : ux_reg;
    assign mul_b = (state_reg == pcr_pkg::ST_MRX || state_reg == pcr_pkg::ST_MRY) ?
                   {2'b00, r_eff} : mul_a;
    assign prod  = mul_a * mul_b;

    logic                       sqrt_start, sqrt_done, div_start, divx_done, divy_done;
    logic [pcr_pkg::DIFF_W-1:0] sqrt_root;
    logic [XW-1:0]              qx, qy;

    assign sqrt_start = (state_reg == pcr_pkg::ST_SQY);
    assign div_start  = (state_reg == pcr_pkg::ST_MRY);

    pcr_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sx_reg + prod),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    pcr_div u_divx (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (px_reg),
        .divisor  (dist_reg),
        .quotient (qx),
        .done     (divx_done)
    );

    pcr_div u_divy (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[pcr_pkg::PROD_W-1:0]),
        .divisor  (dist_reg),
        .quotient (qy),
        .done     (divy_done)
    );

    logic signed [XW-1:0] nax, nay;
    assign nax = negx_reg ? ax_reg - qx : ax_reg + qx;
    assign nay = negy_reg ? ay_reg - qy : ay_reg + qy;

    // result buffer
    logic [2*XW-1:0] buf_mem [DEPTH];
    logic [2*XW-1:0] rd_data_reg;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [2*XW-1:0] wr_data;
    logic [NW-1:0]   n_close;

    assign n_close = fin_reg ? n_reg + NW'(1) : n_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = n_reg[AW-1:0];
        wr_data = {vy_reg, vx_reg};
        pop     = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            pcr_pkg::ST_IDLE:
            begin
                if (vq.valid)
                begin
                    pop = 1'b1;
                    if (!started_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {vq.data.y, vq.data.x};
                        state_next = pcr_pkg::ST_RD;
                    end
                    else
                        state_next = pcr_pkg::ST_SQX;
                end
            end
            pcr_pkg::ST_SQX:   state_next = pcr_pkg::ST_SQY;
            pcr_pkg::ST_SQY:   state_next = pcr_pkg::ST_SQRT;
            pcr_pkg::ST_SQRT:  if (sqrt_done) state_next = pcr_pkg::ST_CHECK;
            pcr_pkg::ST_CHECK:
            begin
                if (dist_reg < {2'b00, r_eff} || chords_reg == CW'(MAX_CHORDS))
                    state_next = pcr_pkg::ST_CLOSE;
                else
                    state_next = pcr_pkg::ST_MRX;
            end
            pcr_pkg::ST_MRX:   state_next = pcr_pkg::ST_MRY;
            pcr_pkg::ST_MRY:   state_next = pcr_pkg::ST_DIV;
            pcr_pkg::ST_DIV:   if (divx_done && divy_done) state_next = pcr_pkg::ST_MOVE;
            pcr_pkg::ST_MOVE:
            begin
                wr_en      = 1'b1;
                wr_data    = {nay, nax};
                state_next = pcr_pkg::ST_SQX;
            end
            pcr_pkg::ST_CLOSE:
            begin
                wr_en      = fin_reg;
                state_next = (n_close == '0) ? pcr_pkg::ST_IDLE : pcr_pkg::ST_RD;
            end
            pcr_pkg::ST_RD:    state_next = pcr_pkg::ST_OUT;
            pcr_pkg::ST_OUT:
            begin
                if (m_tready)
                    state_next = (NW'(rd_idx_reg) == n_reg - NW'(1)) ?
                                 pcr_pkg::ST_IDLE : pcr_pkg::ST_RD;
            end
            default:           state_next = pcr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_mem[wr_addr] <= wr_data;
        rd_data_reg <= buf_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pcr_pkg::ST_IDLE;
            started_reg <= 1'b0;
            ax_reg      <= '0;
            ay_reg      <= '0;
            n_reg       <= '0;
            chords_reg  <= '0;
            rd_idx_reg  <= '0;
            over_reg    <= 1'b0;
            end_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                pcr_pkg::ST_IDLE:
                begin
                    if (vq.valid)
                    begin
                        chords_reg <= '0;
                        over_reg   <= 1'b0;
                        rd_idx_reg <= '0;
                        if (!started_reg)
                        begin
                            n_reg       <= NW'(1);
                            ax_reg      <= vq.data.x;
                            ay_reg      <= vq.data.y;
                            started_reg <= !vq.data.fin;
                            end_reg     <= vq.data.fin;
                        end
                        else
                            n_reg <= '0;
                    end
                end
                pcr_pkg::ST_CHECK:
                begin
                    if (dist_reg >= {2'b00, r_eff} && chords_reg == CW'(MAX_CHORDS))
                        over_reg <= 1'b1;
                end
                pcr_pkg::ST_MOVE:
                begin
                    ax_reg     <= nax;
                    ay_reg     <= nay;
                    n_reg      <= n_reg + NW'(1);
                    chords_reg <= chords_reg + CW'(1);
                end
                pcr_pkg::ST_CLOSE:
                begin
                    n_reg      <= n_close;
                    end_reg    <= fin_reg;
                    rd_idx_reg <= '0;
                    if (fin_reg)
                    begin
                        ax_reg      <= vx_reg;
                        ay_reg      <= vy_reg;
                        started_reg <= 1'b0;
                    end
                end
                pcr_pkg::ST_OUT:
                begin
                    if (m_tready)
                        rd_idx_reg <= rd_idx_reg + AW'(1);
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == pcr_pkg::ST_IDLE && vq.valid)
        begin
            vx_reg  <= vq.data.x;
            vy_reg  <= vq.data.y;
            fin_reg <= vq.data.fin;
        end
        if (state_reg == pcr_pkg::ST_SQX)
        begin
            negx_reg <= dx[pcr_pkg::DIFF_W-1];
            negy_reg <= dy[pcr_pkg::DIFF_W-1];
            ux_reg   <= dx[pcr_pkg::DIFF_W-1] ? -dx : dx;
            uy_reg   <= dy[pcr_pkg::DIFF_W-1] ? -dy : dy;
            sx_reg   <= prod;
        end
        if (sqrt_done)
            dist_reg <= sqrt_root;
        if (state_reg == pcr_pkg::ST_MRX)
            px_reg <= prod[pcr_pkg::PROD_W-1:0];
    end

    logic last_word;
    assign last_word = (NW'(rd_idx_reg) == n_reg - NW'(1));

    assign m_tvalid   = (state_reg == pcr_pkg::ST_OUT);
    assign m_tdata    = rd_data_reg;
    assign m_tlast    = end_reg && last_word;
    assign m_tuser[0] = last_word;
    assign m_tuser[1] = over_reg;

endmodule

// ----- design/pcr_vertex_fifo.sv -----
module pcr_vertex_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pcr_pkg::vertex_t in_data,
    output pcr_pkg::vq_out_t q,
    input  logic             pop
);

    pcr_pkg::vertex_t ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, do_pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (cnt_reg != 2'd0);
    assign q.valid  = (cnt_reg != 2'd0);
    assign q.data   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ----- design/pcr_sqrt.sv -----
module pcr_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcr_pkg::SQ_W-1:0]    radicand,
    output logic [pcr_pkg::DIFF_W-1:0]  root,
    output logic                        done
);

    logic [pcr_pkg::SQ_W-1:0]   rad_reg;
    logic [35:0]                rem_reg;
    logic [pcr_pkg::DIFF_W-1:0] root_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic [35:0]                rem_sh, trial;

    // one result bit per cycle, 33 steps
    assign rem_sh = {rem_reg[33:0], rad_reg[pcr_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(pcr_pkg::DIFF_W - 1);
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                rad_reg <= {rad_reg[pcr_pkg::SQ_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[pcr_pkg::DIFF_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[pcr_pkg::DIFF_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

endmodule

// ----- design/pcr_div.sv -----
module pcr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pcr_pkg::PROD_W-1:0]  dividend,
    input  logic [pcr_pkg::DIFF_W-1:0]  divisor,
    output logic [pcr_pkg::COORD_W-1:0] quotient,
    output logic                        done
);

    logic [pcr_pkg::PROD_W-1:0] dvd_reg;
    logic [pcr_pkg::DIFF_W-1:0] dsr_reg, rem_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic [pcr_pkg::DIFF_W:0]   rem_sh, rem_sub;
    logic                       qbit;

    // restoring divide, quotient bits shift in where dividend bits leave
    assign rem_sh   = {rem_reg, dvd_reg[pcr_pkg::PROD_W-1]};
    assign rem_sub  = rem_sh - {1'b0, dsr_reg};
    assign qbit     = (rem_sh >= {1'b0, dsr_reg});
    assign quotient = dvd_reg[pcr_pkg::COORD_W-1:0];
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(pcr_pkg::PROD_W - 1);
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[pcr_pkg::PROD_W-2:0], qbit};
                rem_reg <= qbit ? rem_sub[pcr_pkg::DIFF_W-1:0] : rem_sh[pcr_pkg::DIFF_W-1:0];
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

endmodule
